FILE: sv/atrp_pkg.sv
// ----------------------------------------------------------------------------
// AT response parser package
// Parser state encoding, status codes, command codes, character constants
// and the per-byte decision record shared by the parser modules.
// ----------------------------------------------------------------------------
package atrp_pkg;

    // Parser states. The numeric code of a state is reported as the error
    // state when a syntax error is detected in it.
    typedef enum logic [3:0] {
        S_WAIT_CR    = 4'd0,
        S_WAIT_LF    = 4'd1,
        S_FIRST      = 4'd2,
        S_GOT_O      = 4'd3,
        S_GOT_E      = 4'd4,
        S_GOT_ER     = 4'd5,
        S_GOT_ERR    = 4'd6,
        S_GOT_ERRO   = 4'd7,
        S_FINAL_CR   = 4'd8,
        S_FINAL_LF   = 4'd9,
        S_INFO_FIRST = 4'd10,
        S_INFO_TEXT  = 4'd11,
        S_INFO_LF    = 4'd12,
        S_AFTER_LINE = 4'd13,
        S_BLANK_LF   = 4'd14,
        S_RESULT     = 4'd15
    } t_state;

    typedef enum logic [1:0] {
        ST_NOT_READY = 2'd0,
        ST_READY     = 2'd1,
        ST_ERROR     = 2'd2
    } t_status;

    localparam logic CMD_PARSE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_O     = 8'h4F;
    localparam logic [7:0] C_E     = 8'h45;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_K     = 8'h4B;
    localparam logic [7:0] C_R     = 8'h52;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_TILDE = 8'h7E;

    // Decision taken for one received byte.
    typedef struct packed {
        t_state  next_state;
        t_status status;
        logic    clear_resp;
        logic    set_ok;
        logic    clr_ok;
        logic    store_char;
        logic    end_line;
    } t_step;

endpackage

FILE: sv/atrp_if.sv
// ----------------------------------------------------------------------------
// AT response parser channels
// Request channel (parse or read beats) and response channel, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface atrp_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;
    logic [2:0] read_line;
    logic [5:0] read_col;

    modport source (output valid, cmd, rx_byte, read_line, read_col, input ready);
    modport sink   (input valid, cmd, rx_byte, read_line, read_col, output ready);
endinterface

interface atrp_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] error_state;
    logic       response_ok;
    logic [3:0] lines_stored;
    logic [7:0] read_char;
    logic [6:0] read_len;

    modport source (output valid, status, error_state, response_ok, lines_stored,
                    read_char, read_len, input ready);
    modport sink   (input valid, status, error_state, response_ok, lines_stored,
                    read_char, read_len, output ready);
endinterface

FILE: sv/atrp_decode.sv
// ----------------------------------------------------------------------------
// AT response parser byte decoder
// Decides the next parser state, the status and the storage actions for one
// received byte in the current state.
// ----------------------------------------------------------------------------
module atrp_decode (
    input  atrp_pkg::t_state i_state,
    input  logic [7:0]       i_byte,
    output atrp_pkg::t_step  o_step
);
    import atrp_pkg::*;

    t_state  w_next;
    t_status w_kind;
    logic    w_printable;

    assign w_printable = (i_byte >= C_SPACE) && (i_byte <= C_TILDE);

    // Next state. Anything not matched is a syntax error back to the start.
    always_comb begin
        w_next = S_WAIT_CR;
        w_kind = ST_ERROR;
        unique case (i_state)
            S_WAIT_CR: begin
                if (i_byte == C_CR) begin
                    w_next = S_WAIT_LF;
                    w_kind = ST_NOT_READY;
                end
            end
            S_WAIT_LF: begin
                if (i_byte == C_LF) begin
                    w_next = S_FIRST;
                    w_kind = ST_NOT_READY;
                end
            end
            S_FIRST: begin
                if (i_byte == C_O) begin
                    w_next = S_GOT_O;
                    w_kind = ST_NOT_READY;
                end else if (i_byte == C_E) begin
                    w_next = S_GOT_E;
                    w_kind = ST_NOT_READY;
                end else if (i_byte == C_PLUS) begin
                    w_next = S_INFO_FIRST;
                    w_kind = ST_NOT_READY;
                end
            end
            S_GOT_O: begin
                if (i_byte == C_K) begin
                    w_next = S_FINAL_CR;
                    w_kind = ST_NOT_READY;
                end
            end
            S_GOT_E: begin
                if (i_byte == C_R) begin
                    w_next = S_GOT_ER;
                    w_kind = ST_NOT_READY;
                end
            end
            S_GOT_ER: begin
                if (i_byte == C_R) begin
                    w_next = S_GOT_ERR;
                    w_kind = ST_NOT_READY;
                end
            end
            S_GOT_ERR: begin
                if (i_byte == C_O) begin
                    w_next = S_GOT_ERRO;
                    w_kind = ST_NOT_READY;
                end
            end
            S_GOT_ERRO: begin
                if (i_byte == C_R) begin
                    w_next = S_FINAL_CR;
                    w_kind = ST_NOT_READY;
                end
            end
            S_FINAL_CR: begin
                if (i_byte == C_CR) begin
                    w_next = S_FINAL_LF;
                    w_kind = ST_NOT_READY;
                end
            end
            S_FINAL_LF: begin
                if (i_byte == C_LF) begin
                    w_next = S_WAIT_CR;
                    w_kind = ST_READY;
                end
            end
            S_INFO_FIRST: begin
                if (w_printable) begin
                    w_next = S_INFO_TEXT;
                    w_kind = ST_NOT_READY;
                end
            end
            S_INFO_TEXT: begin
                if (w_printable) begin
                    w_next = S_INFO_TEXT;
                    w_kind = ST_NOT_READY;
                end else if (i_byte == C_CR) begin
                    w_next = S_INFO_LF;
                    w_kind = ST_NOT_READY;
                end
            end
            S_INFO_LF: begin
                if (i_byte == C_LF) begin
                    w_next = S_AFTER_LINE;
                    w_kind = ST_NOT_READY;
                end
            end
            S_AFTER_LINE: begin
                if (i_byte == C_PLUS) begin
                    w_next = S_INFO_FIRST;
                    w_kind = ST_NOT_READY;
                end else if (i_byte == C_CR) begin
                    w_next = S_BLANK_LF;
                    w_kind = ST_NOT_READY;
                end
            end
            S_BLANK_LF: begin
                if (i_byte == C_LF) begin
                    w_next = S_RESULT;
                    w_kind = ST_NOT_READY;
                end
            end
            S_RESULT: begin
                if (i_byte == C_O) begin
                    w_next = S_GOT_O;
                    w_kind = ST_NOT_READY;
                end else if (i_byte == C_E) begin
                    w_next = S_GOT_E;
                    w_kind = ST_NOT_READY;
                end
            end
            default: begin
                w_next = S_WAIT_CR;
                w_kind = ST_ERROR;
            end
        endcase
    end

    // Actions on the response record.
    always_comb begin
        o_step            = '0;
        o_step.next_state = w_next;
        o_step.status     = w_kind;
        o_step.clear_resp = (i_state == S_WAIT_CR);
        o_step.set_ok     = (i_state == S_GOT_O) && (i_byte == C_K);
        o_step.clr_ok     = (i_state == S_GOT_ERRO) && (i_byte == C_R);
        o_step.store_char = ((i_state == S_INFO_FIRST) || (i_state == S_INFO_TEXT))
                            && w_printable;
        o_step.end_line   = (i_state == S_INFO_TEXT) && (i_byte == C_CR);
    end

endmodule

FILE: sv/at_response_parser_core.sv
// A beat is captured in the input register, and its result in the response register.
// Throughput: one beat per cycle while responses are taken; one parser step sits between the input
// register and the response register, and the line store is read in the same step.
// Reset (synchronous, active low) returns the parser to awaiting the first CR,
// clears the OK flag, the line count and the column, and empties both pipeline stages.
// The line store and the line length table are not cleared by reset.
// ----------------------------------------------------------------------------
// AT response parser core
// Parses a modem AT response byte by byte, stores the text of the '+'
// information lines and serves reads of stored characters and line lengths.
// ----------------------------------------------------------------------------
module at_response_parser_core #(
    parameter int MAX_LINES      = 8,
    parameter int MAX_LINE_CHARS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    atrp_req_if.sink  i_req,
    atrp_rsp_if.source o_rsp
);
    import atrp_pkg::*;

    // Width of the line count and of the column (both reach their limit).
    localparam int CNW   = $clog2(MAX_LINES + 1);
    localparam int CW    = $clog2(MAX_LINE_CHARS + 1);
    // Index widths of the length table and of the character store.
    localparam int LW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int DEPTH = MAX_LINES * MAX_LINE_CHARS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Compare width for a requested line against the count (count < 256).
    localparam int CMPW  = 8;
    // Compare width for a requested column against a line length.
    localparam int CPW   = (CW > 6) ? CW : 6;

    // ------------------------------------------------------------------
    // Input register stage. A beat waits here until the response register
    // can take its result; ready stays high whenever that stage moves.
    // ------------------------------------------------------------------
    logic       r_a_valid;
    logic       r_a_cmd;
    logic [7:0] r_a_byte;
    logic [2:0] r_a_line;
    logic [5:0] r_a_col;

    // Parser state and the record of the current response.
    t_state           r_state;
    logic             r_ok;
    logic [CNW-1:0]   r_line_count;
    logic [CW-1:0]    r_column;

    t_state           n_state;
    logic             n_ok;
    logic [CNW-1:0]   n_line_count;
    logic [CW-1:0]    n_column;

    // Line text store and line length table, each with a registered read.
    logic [7:0]       r_char_mem [DEPTH];
    logic [CW-1:0]    r_len_mem  [MAX_LINES];
    logic [7:0]       r_char_q;
    logic [CW-1:0]    r_len_q;

    // Response register stage.
    logic             r_b_valid;
    t_status          r_b_status;
    logic [3:0]       r_b_err;
    logic             r_b_ok;
    logic [3:0]       r_b_lines;
    logic [5:0]       r_b_col;
    logic             r_b_sel_mem;
    logic             r_b_sel_col;
    logic [CW-1:0]    r_b_colsnap;

    logic             w_accept;
    logic             w_adv;
    logic             w_parse;
    t_step            w_step;
    logic             w_char_we;
    logic             w_len_we;
    logic [AW-1:0]    w_wr_addr;
    logic [AW-1:0]    w_rd_addr;
    logic [CMPW-1:0]  w_ln_ext;
    logic [CMPW-1:0]  w_lc_ext;
    logic             w_in_range;
    logic             w_sel_mem;
    logic             w_sel_col;
    logic [CW-1:0]    w_rlen;

    // The input stage moves forward when the response register is empty or
    // its beat is being taken in this cycle.
    assign w_adv       = r_a_valid && (!r_b_valid || o_rsp.ready);
    assign i_req.ready = !r_a_valid || w_adv;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_parse     = (r_a_cmd == CMD_PARSE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_accept) begin
            r_a_valid <= 1'b1;
        end else if (w_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_cmd  <= i_req.cmd;
            r_a_byte <= i_req.rx_byte;
            r_a_line <= i_req.read_line;
            r_a_col  <= i_req.read_col;
        end
    end

    // ------------------------------------------------------------------
    // Per-byte decision of the parser state machine.
    // ------------------------------------------------------------------
    atrp_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_a_byte),
        .o_step  (w_step)
    );

    // Update of the response record. A byte in the start state opens a new
    // response: the flag, the count and the column are cleared first.
    // Characters past the column limit, or once all lines are used, are
    // dropped; a line end past the line limit neither stores a length nor
    // clears the column.
    always_comb begin
        n_state      = r_state;
        n_ok         = r_ok;
        n_line_count = r_line_count;
        n_column     = r_column;
        w_char_we    = 1'b0;
        w_len_we     = 1'b0;
        if (w_adv && w_parse) begin
            n_state = w_step.next_state;
            if (w_step.clear_resp) begin
                n_ok         = 1'b0;
                n_line_count = '0;
                n_column     = '0;
            end
            if (w_step.set_ok) begin
                n_ok = 1'b1;
            end
            if (w_step.clr_ok) begin
                n_ok = 1'b0;
            end
            if (w_step.store_char && (r_column < CW'(MAX_LINE_CHARS))
                    && (r_line_count < CNW'(MAX_LINES))) begin
                w_char_we = 1'b1;
                n_column  = r_column + CW'(1);
            end
            if (w_step.end_line && (r_line_count < CNW'(MAX_LINES))) begin
                w_len_we     = 1'b1;
                n_line_count = r_line_count + CNW'(1);
                n_column     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_WAIT_CR;
            r_ok         <= 1'b0;
            r_line_count <= '0;
            r_column     <= '0;
        end else begin
            r_state      <= n_state;
            r_ok         <= n_ok;
            r_line_count <= n_line_count;
            r_column     <= n_column;
        end
    end

    // ------------------------------------------------------------------
    // Line store. Row = line index, column within the row = character.
    // A read beat fetches both the character and the line length; whether
    // they are shown is settled by the selects held in the response stage.
    // ------------------------------------------------------------------
    assign w_wr_addr = AW'(int'(r_line_count) * MAX_LINE_CHARS + int'(r_column));
    assign w_rd_addr = AW'(int'(r_a_line) * MAX_LINE_CHARS + int'(r_a_col));

    always_ff @(posedge i_clk) begin
        if (w_char_we) begin
            r_char_mem[w_wr_addr] <= r_a_byte;
        end
        if (w_adv) begin
            r_char_q <= r_char_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_len_we) begin
            r_len_mem[LW'(r_line_count)] <= r_column;
        end
        if (w_adv) begin
            r_len_q <= r_len_mem[LW'(r_a_line)];
        end
    end

    // A completed line reports its stored length; the line in progress
    // reports the current column; any other line reports zero.
    assign w_ln_ext   = CMPW'(r_a_line);
    assign w_lc_ext   = CMPW'(r_line_count);
    assign w_in_range = (w_ln_ext < CMPW'(MAX_LINES));
    assign w_sel_mem  = w_in_range && (w_ln_ext < w_lc_ext);
    assign w_sel_col  = w_in_range && (w_ln_ext == w_lc_ext);

    // ------------------------------------------------------------------
    // Response register stage.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_status  <= w_parse ? w_step.status : ST_NOT_READY;
            // The error state is the state the byte arrived in; an error in
            // the start state therefore reads as zero.
            r_b_err     <= (w_parse && (w_step.status == ST_ERROR)) ? 4'(r_state) : 4'd0;
            r_b_ok      <= n_ok;
            r_b_lines   <= 4'(n_line_count);
            r_b_col     <= r_a_col;
            r_b_sel_mem <= !w_parse && w_sel_mem;
            r_b_sel_col <= !w_parse && w_sel_col;
            r_b_colsnap <= r_column;
        end
    end

    always_comb begin
        if (r_b_sel_mem) begin
            w_rlen = r_len_q;
        end else if (r_b_sel_col) begin
            w_rlen = r_b_colsnap;
        end else begin
            w_rlen = '0;
        end
    end

    assign o_rsp.valid        = r_b_valid;
    assign o_rsp.status       = r_b_status;
    assign o_rsp.error_state  = r_b_err;
    assign o_rsp.response_ok  = r_b_ok;
    assign o_rsp.lines_stored = r_b_lines;
    assign o_rsp.read_len     = 7'(w_rlen);
    // A column at or past the line length reads as zero.
    assign o_rsp.read_char    = (CPW'(r_b_col) < CPW'(w_rlen)) ? r_char_q : 8'd0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_count <= CNW'(MAX_LINES))
        else $error("line count above its limit");

    a_column_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column <= CW'(MAX_LINE_CHARS))
        else $error("column above its limit");

    a_end_to_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_parse && (w_step.status != ST_NOT_READY)) |=> (r_state == S_WAIT_CR))
        else $error("parser did not return to start after completion or error");

    a_new_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_parse && (r_state == S_WAIT_CR))
            |=> ((r_line_count == '0) && (r_column == '0) && !r_ok))
        else $error("new response did not clear the response record");

endmodule
